// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the sorted priority queue core and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Item mode codes.
  localparam logic MODE_ENQUEUE = 1'b0;
  localparam logic MODE_DEQUEUE = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // One stored entry of the queue.
  typedef struct packed {
    logic [15:0] prio;
    logic [31:0] value;
  } entry_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

  // One result word as held in the output buffer.
  typedef struct packed {
    status_t     status;
    logic [31:0] removed_value;
    logic [15:0] removed_priority;
    logic [6:0]  occupancy;
  } result_t;

endpackage

// ===== rtl/core/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted shift-register queue.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic                occupied,
  input  spq_pkg::entry_t     new_entry,
  input  spq_pkg::entry_t     left_entry,
  input  logic                left_gt,
  input  spq_pkg::entry_t     right_entry,
  output spq_pkg::entry_t     entry,
  output logic                gt
);

  // The slot outranks the newcomer when it holds a strictly larger priority,
  // so equal priorities keep their arrival order.
  assign gt = occupied && ($signed(entry.prio) > $signed(new_entry.prio));

  always_ff @(posedge clk) begin
    if (ctrl.insert && (gt || !occupied)) begin
      entry <= left_gt ? left_entry : new_entry;
    end else if (ctrl.remove) begin
      entry <= right_entry;
    end
  end

endmodule

// ===== rtl/core/spq_out_buf.sv =====
// ----------------------------------------------------------------------------
// spq_out_buf
// Output register with a skid stage for result words.
// ----------------------------------------------------------------------------
module spq_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  spq_pkg::result_t push_word,
  output logic             full,
  output logic             valid,
  input  logic             stall,
  output spq_pkg::result_t word
);

  logic             skid_valid;
  spq_pkg::result_t skid_word;
  logic             take;

  assign take = valid && !stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!valid || take) begin
      if (skid_valid) begin
        valid      <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!valid || take) begin
      if (skid_valid) begin
        word <= skid_word;
      end else if (push) begin
        word <= push_word;
      end
    end else if (push) begin
      skid_word <= push_word;
    end
  end

endmodule

// ===== rtl/core/sorted_priority_queue_core.sv =====
// A result word is formed when its item word is accepted and is registered in the output buffer.
// Throughput: one item per cycle while item_stall is low; every cell compares and shifts in parallel in that cycle.
// The two-word output buffer lets the core take an item while one result still waits.
// Reset (rst, synchronous) empties the queue and the output buffer at once.
// The cell contents are not reset; only slots below the occupancy are ever read.
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Priority queue kept sorted in a row of shift-register cells, head in cell 0.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  // Item channel.
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               mode,
  input  logic signed [31:0] item_value,
  input  logic signed [15:0] item_priority,
  // Result channel.
  output logic               result_valid,
  input  logic               result_stall,
  output logic [1:0]         status,
  output logic signed [31:0] removed_value,
  output logic signed [15:0] removed_priority,
  output logic [6:0]         occupancy
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Number of entries held; the occupied cells are always a prefix of the row.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic                accept;
  logic                buf_full;
  logic                is_full;
  logic                is_empty;
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::entry_t     new_entry;
  spq_pkg::result_t    res_word;
  spq_pkg::result_t    out_word;

  spq_pkg::entry_t     cell_entry [CAPACITY];
  logic [CAPACITY-1:0] cell_gt;
  logic [CAPACITY-1:0] cell_occ;

  logic [CNT_W+6:0]    count_ext;

  // An item is refused only while the skid stage is holding a word.
  assign item_stall = buf_full;
  assign accept     = item_valid && !item_stall;

  assign is_full  = (count == CNT_W'(CAPACITY));
  assign is_empty = (count == '0);

  assign new_entry.value = item_value;
  assign new_entry.prio  = item_priority;

  // An insertion ripples every entry of larger priority one cell towards the
  // tail; a removal moves the whole row one cell towards the head.
  assign ctrl.insert = accept && (mode == spq_pkg::MODE_ENQUEUE) && !is_full;
  assign ctrl.remove = accept && (mode == spq_pkg::MODE_DEQUEUE) && !is_empty;

  always_comb begin
    count_next = count;
    if (ctrl.insert) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.remove) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // The row of cells. Each cell sees its neighbours' contents and whether the
  // cell ahead of it also outranks the newcomer.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::entry_t left_entry;
    spq_pkg::entry_t right_entry;
    logic            left_gt;

    assign cell_occ[i] = (count > CNT_W'(i));

    if (i == 0) begin : g_head
      assign left_entry = new_entry;
      assign left_gt    = 1'b0;
    end else begin : g_body
      assign left_entry = cell_entry[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (cell_occ[i]),
      .new_entry   (new_entry),
      .left_entry  (left_entry),
      .left_gt     (left_gt),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .gt          (cell_gt[i])
    );
  end

  // The occupancy is reported in seven bits and wraps for very large queues.
  assign count_ext = {7'd0, count_next};

  always_comb begin
    res_word.removed_value    = '0;
    res_word.removed_priority = '0;
    res_word.occupancy        = count_ext[6:0];
    if (mode == spq_pkg::MODE_ENQUEUE) begin
      res_word.status = is_full ? spq_pkg::STAT_FULL : spq_pkg::STAT_DONE;
    end else begin
      res_word.status = is_empty ? spq_pkg::STAT_EMPTY : spq_pkg::STAT_DONE;
      if (!is_empty) begin
        res_word.removed_value    = cell_entry[0].value;
        res_word.removed_priority = cell_entry[0].prio;
      end
    end
  end

  spq_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_word (res_word),
    .full      (buf_full),
    .valid     (result_valid),
    .stall     (result_stall),
    .word      (out_word)
  );

  assign status           = out_word.status;
  assign removed_value    = out_word.removed_value;
  assign removed_priority = out_word.removed_priority;
  assign occupancy        = out_word.occupancy;

endmodule

// ===== rtl/core/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the sorted priority queue core.
// ----------------------------------------------------------------------------
module spq_checker #(
  parameter int CAPACITY = 64
) (
  input logic        clk,
  input logic        rst,
  input logic        item_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [1:0]  status,
  input logic [31:0] removed_value,
  input logic [15:0] removed_priority,
  input logic [6:0]  occupancy
);

  localparam logic [6:0] CAP_OCC = 7'(CAPACITY);

  // A result word that is held back stays offered.
  a_result_held : assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result word dropped while stalled");

  // The item channel is only refused while a result word is on offer.
  a_stall_has_word : assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("item channel stalled with no result word offered");

  // Reset leaves nothing on the result channel.
  a_reset_clears : assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result word present after reset");

  // A refused dequeue reports an empty queue and no removed entry.
  a_empty_word : assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == spq_pkg::STAT_EMPTY) |->
      (occupancy == 7'd0) && (removed_value == '0) && (removed_priority == '0))
    else $error("empty status with non-zero fields");

  // A refused enqueue reports a full queue and no removed entry.
  a_full_word : assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == spq_pkg::STAT_FULL) |->
      (occupancy == CAP_OCC) && (removed_value == '0) && (removed_priority == '0))
    else $error("full status with wrong fields");

endmodule

bind sorted_priority_queue_core spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
  .clk              (clk),
  .rst              (rst),
  .item_stall       (item_stall),
  .result_valid     (result_valid),
  .result_stall     (result_stall),
  .status           (status),
  .removed_value    (removed_value),
  .removed_priority (removed_priority),
  .occupancy        (occupancy)
);
